@@ design/usb_control_endpoint_responder_assert.svh @@
// assertion macros for the control endpoint responder
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_ASSERT_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_ASSERT_SVH

// check that a condition implies a consequence on the same edge
`define UCE_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// check that a condition implies a consequence on the next edge
`define UCE_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/uce_pkg.sv @@
// ----------------------------------------------------------------------------
// uce_pkg
// types and constants shared by the control endpoint responder
// ----------------------------------------------------------------------------
`default_nettype none
package uce_pkg;
  localparam int unsigned NumEndpointsDefault = 16;
  localparam int unsigned MaxPacketDefault    = 64;
  localparam int unsigned CfgIdxW             = 2;
  localparam int unsigned CfgDataW            = 10;

  localparam logic [1:0] CfgCfgLen     = 2'd0;
  localparam logic [1:0] CfgTestLen    = 2'd1;
  localparam logic [1:0] CfgTestPresent = 2'd2;
  localparam logic [1:0] CfgCtrlEp     = 2'd3;

  localparam logic [1:0] FuncSetup = 2'd0;
  localparam logic [1:0] FuncOut   = 2'd1;
  localparam logic [1:0] FuncInDone = 2'd2;
  localparam logic [1:0] FuncReset = 2'd3;

  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActData  = 2'd1;
  localparam logic [1:0] ActZlp   = 2'd2;
  localparam logic [1:0] ActStall = 2'd3;

  localparam logic [2:0] SrcDevDesc = 3'd0;
  localparam logic [2:0] SrcCfgDesc = 3'd1;
  localparam logic [2:0] SrcCfgVal  = 3'd2;
  localparam logic [2:0] SrcStatus  = 3'd3;
  localparam logic [2:0] SrcZeros   = 3'd4;
  localparam logic [2:0] SrcTest    = 3'd5;

  localparam logic [1:0] HaltNone  = 2'd0;
  localparam logic [1:0] HaltSet   = 2'd1;
  localparam logic [1:0] HaltClear = 2'd2;

  localparam logic [7:0] ReqGetStatus  = 8'd0;
  localparam logic [7:0] ReqClrFeature = 8'd1;
  localparam logic [7:0] ReqSetFeature = 8'd3;
  localparam logic [7:0] ReqSetAddress = 8'd5;
  localparam logic [7:0] ReqGetDesc    = 8'd6;
  localparam logic [7:0] ReqGetConfig  = 8'd8;
  localparam logic [7:0] ReqSetConfig  = 8'd9;
  localparam logic [7:0] ReqGetIface   = 8'd10;
  localparam logic [7:0] ReqSetIface   = 8'd11;
  localparam logic [7:0] ReqSynchFrame = 8'd12;
  localparam logic [7:0] ReqVendorTest = 8'h7C;

  localparam logic [7:0] DescDevice = 8'h01;
  localparam logic [7:0] DescConfig = 8'h02;
  localparam logic [9:0] DevDescLen = 10'd18;

  // classified request kind handed from front to back
  typedef enum logic [3:0] {
    KStall, KDevDesc, KCfgDesc, KSetAddr, KSetCfg, KGetCfg, KSetFeat, KClrFeat,
    KGetStatus, KSetIface, KGetIface, KSynch, KVendor, KOut, KInDone, KBusReset
  } kind_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  pkt_len;
    logic [7:0]  request_type;
    logic [7:0]  request;
    logic [15:0] setup_value;
    logic [15:0] setup_index;
    logic [15:0] setup_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  data_source;
    logic [9:0]  send_len;
    logic        multi_packet;
    logic        add_zlp;
    logic [15:0] status_word;
    logic [7:0]  ep_num;
    logic        ep_dir_in;
    logic [1:0]  halt_op;
    logic        apply_address;
    logic [6:0]  device_address;
    logic [1:0]  usb_state;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic        pkt_ok;
    logic [4:0]  recip;
    logic [7:0]  ep;
    logic        dir;
    logic [7:0]  value_lo;
    logic        value_zero;
    logic [9:0]  len;       // low ten bits of the requested length
    logic        len_big;   // requested length above 1023
  } cmd_t;
endpackage
`default_nettype wire

@@ design/uce_front.sv @@
// ----------------------------------------------------------------------------
// uce_front
// accepts events and classifies setup requests into commands
// ----------------------------------------------------------------------------
`default_nettype none
module uce_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                stall_o,
  input  uce_pkg::in_item_t   item_i,
  input  wire                 test_present_i,
  output logic                cmd_valid_o,
  input  wire                 cmd_stall_i,
  output uce_pkg::cmd_t       cmd_o
);
  import uce_pkg::*;

  cmd_t cmd_d, cmd_q;
  logic vld_q;
  kind_e k;

  always_comb begin
    k = KStall;
    case (item_i.func)
      FuncSetup: begin
        case (item_i.request)
          ReqGetDesc: begin
            if (item_i.setup_value[15:8] == DescDevice) k = KDevDesc;
            else if (item_i.setup_value[15:8] == DescConfig) k = KCfgDesc;
            else k = KStall;
          end
          ReqSetAddress: k = KSetAddr;
          ReqSetConfig:  k = KSetCfg;
          ReqGetConfig:  k = KGetCfg;
          ReqSetFeature: k = KSetFeat;
          ReqClrFeature: k = KClrFeat;
          ReqGetStatus:  k = KGetStatus;
          ReqSetIface:   k = KSetIface;
          ReqGetIface:   k = KGetIface;
          ReqSynchFrame: k = KSynch;
          default: begin
            if (item_i.request_type[6:5] == 2'b10 && test_present_i
                && item_i.request == ReqVendorTest) k = KVendor;
            else k = KStall;
          end
        endcase
      end
      FuncOut:    k = KOut;
      FuncInDone: k = KInDone;
      default:    k = KBusReset;
    endcase
    cmd_d.kind       = k;
    cmd_d.pkt_ok     = (item_i.func == FuncSetup) ? (item_i.pkt_len == 7'd8)
                                                   : (item_i.pkt_len == 7'd0);
    cmd_d.recip      = item_i.request_type[4:0];
    cmd_d.ep         = item_i.setup_index[7:0];
    cmd_d.dir        = item_i.request_type[7];
    cmd_d.value_lo   = item_i.setup_value[7:0];
    cmd_d.value_zero = (item_i.setup_value == 16'd0);
    cmd_d.len        = item_i.setup_length[9:0];
    cmd_d.len_big    = |item_i.setup_length[15:10];
  end

  assign stall_o     = vld_q && cmd_stall_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!stall_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) cmd_q <= cmd_d;
  end
endmodule
`default_nettype wire

@@ design/uce_fifo.sv @@
// ----------------------------------------------------------------------------
// uce_fifo
// two-entry command queue between classifier and executor
// ----------------------------------------------------------------------------
`default_nettype none
module uce_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  uce_pkg::cmd_t  in_cmd_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output uce_pkg::cmd_t  out_cmd_o
);
  import uce_pkg::*;

  cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;
  assign out_cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end
endmodule
`default_nettype wire

@@ design/uce_back.sv @@
// ----------------------------------------------------------------------------
// uce_back
// executes commands against the control state and registers the result
// ----------------------------------------------------------------------------
`default_nettype none
module uce_back #(
  parameter int unsigned NumEndpoints = uce_pkg::NumEndpointsDefault,
  parameter int unsigned MaxPacket    = uce_pkg::MaxPacketDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cmd_valid_i,
  output logic                cmd_stall_o,
  input  uce_pkg::cmd_t       cmd_i,
  input  wire  [9:0]          cfg_len_i,
  input  wire  [9:0]          test_len_i,
  output logic                valid_o,
  input  wire                 stall_i,
  output uce_pkg::out_item_t  item_o
);
  import uce_pkg::*;
`include "usb_control_endpoint_responder_assert.svh"

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StWaitIn  = 3'd1,
    StStatOut = 3'd2,
    StAddrIn  = 3'd3,
    StCfgIn   = 3'd4,
    StStatIn  = 3'd5
  } stage_e;

  localparam logic [9:0] MaxPkt = 10'(MaxPacket);

  stage_e stage_q, stage_d;
  logic [1:0] dev_q, dev_d;
  logic [6:0] paddr_q, paddr_d;
  logic [7:0] pcfg_q, pcfg_d, ccfg_q, ccfg_d;
  logic [2*NumEndpoints-1:0] halt_q, halt_d;
  out_item_t res_d, res_q;
  logic vld_q, take;
  logic [9:0] wl, ln;
  logic ep_ok;
  logic [$clog2(2*NumEndpoints)-1:0] hbit;

  function automatic logic [9:0] min10(input logic [9:0] a, input logic [9:0] b);
    min10 = (a < b) ? a : b;
  endfunction

  assign cmd_stall_o = vld_q && stall_i;
  assign take = cmd_valid_i && !cmd_stall_o;
  assign valid_o = vld_q;
  assign item_o = res_q;

  always_comb begin
    stage_d = stage_q; dev_d = dev_q; paddr_d = paddr_q;
    pcfg_d = pcfg_q; ccfg_d = ccfg_q; halt_d = halt_q;
    res_d = '0;
    wl = cmd_i.len_big ? 10'h3FF : cmd_i.len;
    ln = '0;
    ep_ok = ({24'd0, cmd_i.ep} < 32'(NumEndpoints));
    hbit = ($clog2(2*NumEndpoints))'({cmd_i.ep, cmd_i.dir});
    case (cmd_i.kind)
      KOut: begin
        if (stage_q == StStatOut && cmd_i.pkt_ok) stage_d = StIdle;
        else begin res_d.action = ActStall; stage_d = StIdle; end
      end
      KInDone: begin
        case (stage_q)
          StAddrIn: begin
            res_d.apply_address = 1'b1; res_d.device_address = paddr_q;
            dev_d = 2'd1; stage_d = StIdle;
          end
          StCfgIn: begin
            ccfg_d = pcfg_q; dev_d = (pcfg_q != 8'd0) ? 2'd2 : 2'd1;
            stage_d = StIdle;
          end
          StStatIn: stage_d = StIdle;
          StWaitIn: stage_d = StStatOut;
          default: ;
        endcase
      end
      KBusReset: begin stage_d = StIdle; dev_d = 2'd0; end
      default: begin
        if (stage_q != StIdle || !cmd_i.pkt_ok || cmd_i.kind == KStall
            || ((cmd_i.kind == KSetFeat || cmd_i.kind == KClrFeat)
                && !cmd_i.value_zero)) begin
          res_d.action = ActStall; stage_d = StIdle;
        end else begin
          res_d.action = ActData; stage_d = StWaitIn;
          case (cmd_i.kind)
            KDevDesc: begin res_d.data_source = SrcDevDesc; ln = min10(DevDescLen, wl); end
            KCfgDesc: begin
              res_d.data_source = SrcCfgDesc; ln = min10(cfg_len_i, wl);
              if (ln >= MaxPkt) begin
                res_d.multi_packet = 1'b1;
                res_d.add_zlp = cmd_i.len_big || (cmd_i.len > cfg_len_i);
              end
            end
            KGetCfg: begin
              res_d.data_source = SrcCfgVal; ln = min10(10'd1, wl);
              res_d.status_word = {8'd0, ccfg_q};
            end
            KGetStatus: begin
              res_d.data_source = SrcStatus; ln = min10(10'd2, wl);
              if (cmd_i.recip == 5'd0) res_d.status_word = 16'd1;
              else if (cmd_i.recip == 5'd2 && ep_ok)
                res_d.status_word = {15'd0, halt_q[hbit]};
            end
            KGetIface: begin res_d.data_source = SrcZeros; ln = min10(10'd1, wl); end
            KSynch:    begin res_d.data_source = SrcZeros; ln = min10(10'd2, wl); end
            KVendor:   begin res_d.data_source = SrcTest; ln = min10(test_len_i, wl); end
            KSetAddr: begin
              res_d.action = ActZlp; stage_d = StAddrIn;
              paddr_d = cmd_i.value_lo[6:0];
            end
            KSetCfg: begin
              res_d.action = ActZlp; stage_d = StCfgIn; pcfg_d = cmd_i.value_lo;
            end
            KSetIface: begin res_d.action = ActZlp; stage_d = StStatIn; end
            default: begin
              res_d.action = ActZlp; stage_d = StStatIn;
              res_d.ep_num = cmd_i.ep; res_d.ep_dir_in = cmd_i.dir;
              res_d.halt_op = (cmd_i.kind == KSetFeat) ? HaltSet : HaltClear;
              if (ep_ok) halt_d[hbit] = (cmd_i.kind == KSetFeat);
            end
          endcase
          res_d.send_len = (res_d.multi_packet || ln < MaxPkt) ? ln : MaxPkt;
        end
      end
    endcase
    res_d.usb_state = dev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StIdle; dev_q <= 2'd0; paddr_q <= '0; pcfg_q <= '0;
      ccfg_q <= '0; halt_q <= '0; vld_q <= 1'b0; res_q <= '0;
    end else begin
      if (!cmd_stall_o) vld_q <= cmd_valid_i;
      if (take) begin
        stage_q <= stage_d; dev_q <= dev_d; paddr_q <= paddr_d;
        pcfg_q <= pcfg_d; ccfg_q <= ccfg_d; halt_q <= halt_d;
        res_q <= res_d;
      end
    end
  end

  `UCE_ASSERT_IMP(a_len_max, clk_i, rst_ni, valid_o && !item_o.multi_packet,
                  item_o.send_len <= MaxPkt)
  `UCE_ASSERT_IMP(a_stall_clean, clk_i, rst_ni, valid_o && item_o.action == ActStall,
                  item_o.send_len == 10'd0 && item_o.halt_op == HaltNone)
  `UCE_ASSERT_NEXT(a_stall_idle, clk_i, rst_ni, take && res_d.action == ActStall,
                   stage_q == StIdle)
endmodule
`default_nettype wire

@@ design/usb_control_endpoint_responder.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder
// endpoint zero responder for usb control transfers
// ----------------------------------------------------------------------------
// One result per event. A front stage registers and classifies each event,
// a two-entry queue decouples it from the executor, which updates the control
// state and registers the result. Events pass front, queue and executor in
// order; a new event is accepted every cycle while the output is taken.
`default_nettype none
module usb_control_endpoint_responder #(
  parameter int unsigned NumEndpoints = uce_pkg::NumEndpointsDefault,
  parameter int unsigned MaxPacket    = uce_pkg::MaxPacketDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              valid_i,
  output logic                             stall_o,
  input  uce_pkg::in_item_t                in_item_i,
  output logic                             valid_o,
  input  wire                              stall_i,
  output uce_pkg::out_item_t               out_item_o,
  input  wire                              cfg_we_i,
  input  wire  [uce_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [uce_pkg::CfgDataW-1:0]     cfg_data_i
);
  import uce_pkg::*;

  logic [9:0] cfg_len_q, test_len_q;
  logic test_present_q;
  logic f_vld, f_stall, b_vld, b_stall;
  cmd_t f_cmd, b_cmd;

  // the control endpoint number has no effect on any result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= '0; test_len_q <= '0; test_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCfgLen:      cfg_len_q <= cfg_data_i;
        CfgTestLen:     test_len_q <= cfg_data_i;
        CfgTestPresent: test_present_q <= cfg_data_i[0];
        CfgCtrlEp:      ;
        default: ;
      endcase
    end
  end

  uce_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .item_i(in_item_i),
    .test_present_i(test_present_q),
    .cmd_valid_o(f_vld), .cmd_stall_i(f_stall), .cmd_o(f_cmd)
  );

  uce_fifo u_fifo (
    .clk_i, .rst_ni, .in_valid_i(f_vld), .in_stall_o(f_stall), .in_cmd_i(f_cmd),
    .out_valid_o(b_vld), .out_stall_i(b_stall), .out_cmd_o(b_cmd)
  );

  uce_back #(.NumEndpoints(NumEndpoints), .MaxPacket(MaxPacket)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_vld), .cmd_stall_o(b_stall), .cmd_i(b_cmd),
    .cfg_len_i(cfg_len_q), .test_len_i(test_len_q),
    .valid_o, .stall_i, .item_o(out_item_o)
  );
endmodule
`default_nettype wire
